>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QTUS_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("qtus: assertion failed");

// next-cycle implication
`define QTUS_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("qtus: assertion failed");

`endif

>>> rtl/qtus_pkg.sv
// ---------------------------------------------------------------------------
// qtus_pkg
// Opcodes, register indexes, reset values and saturation helper for the
// Q-table engine.
// ---------------------------------------------------------------------------
`default_nettype none

package qtus_pkg;

  localparam int Q_W   = 32;
  localparam int CFG_W = 17;

  // opcodes
  localparam logic [1:0] OP_UPDATE     = 2'd0;
  localparam logic [1:0] OP_GREEDY     = 2'd1;
  localparam logic [1:0] OP_EPS_GREEDY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_LEARNING_RATE     = 2'd0;
  localparam logic [1:0] REG_DISCOUNT_FACTOR   = 2'd1;
  localparam logic [1:0] REG_EXPLORE_THRESHOLD = 2'd2;

  localparam logic [CFG_W-1:0] LR_RESET       = 17'd6554;
  localparam logic [CFG_W-1:0] DISCOUNT_RESET = 17'd58982;
  localparam logic [CFG_W-1:0] EXPLORE_RESET  = 17'd6554;

  localparam logic signed [37:0] SUM_MAX = 38'sd2147483647;
  localparam logic signed [37:0] SUM_MIN = -38'sd2147483648;

  // clamp to signed 32 bits; bit 32 of the result flags a clamp
  function automatic logic [32:0] sat32(input logic signed [37:0] v);
    if (v > SUM_MAX) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (v < SUM_MIN) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/q_table_update_and_select.sv
// ---------------------------------------------------------------------------
// q_table_update_and_select
// Q-table engine: Q-learning update of one entry and greedy or
// epsilon-greedy action choice, over a shared multiplier and one table RAM.
//   in_*  : one word per request, taken when in_valid is high and in_stall
//           low; in_stall stays high until the result is in the output register.
//   out_* : one result word per request, held until taken (out_valid high,
//           out_stall low); the next request may start while it waits.
//   cfg_* : register writes, always ready; write only while the block idles.
//   Steps after acceptance (one table RAM, one 35x18 multiplier):
//     update        read entry, scan next row, add lr * reward; if the next row
//                   has a positive entry, also step toward discount * max; write back
//     greedy choice scan min(8, NUM_ACTIONS) entries, bit-serial tie_random
//                   remainder and select if an action is available; opcode 3 unused
//   Exploration skips the scan; each result is followed by a return to idle.
//   Reset: control and configuration registers take their reset values, then a
//   clearing pass zeroes NUM_STATES * NUM_ACTIONS entries; in_stall stays high.
//   A stalled result holds the engine in its final state until taken.
// ---------------------------------------------------------------------------
`default_nettype none

module q_table_update_and_select
  import qtus_pkg::*;
#(
  parameter int NUM_STATES  = 256,
  parameter int NUM_ACTIONS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [7:0]         in_state_index,
  input  wire logic [7:0]         in_next_state_index,
  input  wire logic [2:0]         in_action_index,
  input  wire logic signed [31:0] in_reward,
  input  wire logic [7:0]         in_available_mask,
  input  wire logic [15:0]        in_tie_random,
  input  wire logic [15:0]        in_explore_random,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_chosen_action,
  output logic signed [31:0]      out_new_q_value,
  output logic                    out_explored,
  output logic                    out_saturated,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(NUM_STATES);
  localparam int IDX_W  = $clog2(NUM_ACTIONS);
  localparam int CNT_W  = $clog2(NUM_ACTIONS + 1);
  localparam int GLEN   = (NUM_ACTIONS < 8) ? NUM_ACTIONS : 8;
  localparam logic [7:0] AVAIL_MASK =
    (NUM_ACTIONS >= 8) ? 8'hFF : 8'((1 << NUM_ACTIONS) - 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_PREP, S_RD_E, S_GET_E, S_SCAN,
    S_MUL_R, S_ADD_R, S_MUL_D, S_DIFF, S_MUL_L, S_ADD_L, S_WRITE,
    S_PICK, S_DIV, S_SEL, S_DONE
  } state_t;

  // row index modulo NUM_STATES, by restoring subtraction
  function automatic logic [ROW_W-1:0] row_mod(input logic [7:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (32'(NUM_STATES) << k)) begin
        r = r - (32'(NUM_STATES) << k);
      end
    end
    return ROW_W'(r);
  endfunction

  function automatic logic [IDX_W-1:0] act_mod(input logic [2:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int k = 2; k >= 0; k--) begin
      if (r >= (32'(NUM_ACTIONS) << k)) begin
        r = r - (32'(NUM_ACTIONS) << k);
      end
    end
    return IDX_W'(r);
  endfunction

  state_t                state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CFG_W-1:0]      lr_r, disc_r, thr_r;

  logic [1:0]            op_r, op_nxt;
  logic [7:0]            row_raw_r, row_raw_nxt;
  logic [7:0]            nrow_raw_r, nrow_raw_nxt;
  logic [2:0]            act_raw_r, act_raw_nxt;
  logic signed [31:0]    reward_r, reward_nxt;
  logic [7:0]            avail_r, avail_nxt;
  logic [15:0]           tie_r, tie_nxt;
  logic [15:0]           expl_r, expl_nxt;

  logic [ADDR_W-1:0]     cur_base_r, cur_base_nxt;
  logic [ADDR_W-1:0]     nxt_base_r, nxt_base_nxt;
  logic [IDX_W-1:0]      act_r, act_nxt;
  logic signed [31:0]    q_r, q_nxt;
  logic                  sat_r, sat_nxt;
  logic signed [31:0]    m_r, m_nxt;
  logic                  any_r, any_nxt;
  logic signed [31:0]    best_r, best_nxt;
  logic [7:0]            best_set_r, best_set_nxt;
  logic [7:0]            cand_r, cand_nxt;
  logic                  explored_r, explored_nxt;
  logic [CNT_W-1:0]      iss_r, iss_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic signed [34:0]    diff_r, diff_nxt;
  logic [2:0]            rem_r, rem_nxt;
  logic [3:0]            div_cnt_r, div_cnt_nxt;
  logic [3:0]            cnt_n_r, cnt_n_nxt;
  logic [2:0]            chosen_r, chosen_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            out_chosen_r, out_chosen_nxt;
  logic signed [31:0]    out_q_r, out_q_nxt;
  logic                  out_explored_r, out_explored_nxt;
  logic                  out_sat_r, out_sat_nxt;

  // table RAM: {valid, q}
  logic [32:0]           mem [DEPTH];
  logic [32:0]           mem_rdata_r;
  logic [ADDR_W-1:0]     mem_raddr, mem_waddr;
  logic [32:0]           mem_wdata;
  logic                  mem_we;

  // shared multiplier
  logic signed [34:0]    mul_a;
  logic [CFG_W-1:0]      mul_f;
  logic signed [52:0]    mul_p_r;
  logic signed [36:0]    scaled;
  logic signed [37:0]    sum;
  logic [32:0]           sum_sat;

  logic signed [31:0]    wq;
  logic                  wvalid;
  logic [CNT_W-1:0]      scan_len;
  logic [IDX_W-1:0]      scan_last_idx;
  logic [ADDR_W-1:0]     scan_base;

  assign wq     = $signed(mem_rdata_r[31:0]);
  assign wvalid = mem_rdata_r[32];
  assign scaled = mul_p_r[52:16];
  assign sum    = 38'(scaled) + 38'(q_r);
  assign sum_sat = sat32(sum);

  assign scan_len      = (op_r == OP_UPDATE) ? CNT_W'(NUM_ACTIONS) : CNT_W'(GLEN);
  assign scan_last_idx = (op_r == OP_UPDATE) ? IDX_W'(NUM_ACTIONS - 1) : IDX_W'(GLEN - 1);
  assign scan_base     = (op_r == OP_UPDATE) ? nxt_base_r : cur_base_r;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_chosen_action = out_chosen_r;
  assign out_new_q_value   = out_q_r;
  assign out_explored      = out_explored_r;
  assign out_saturated     = out_sat_r;

  // multiplier operand select
  always_comb begin
    mul_a = 35'(reward_r);
    mul_f = lr_r;
    case (state_r)
      S_MUL_D: begin
        mul_a = 35'(m_r);
        mul_f = disc_r;
      end
      S_MUL_L: begin
        mul_a = diff_r;
        mul_f = lr_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * $signed({1'b0, mul_f});
  end

  // RAM ports
  always_comb begin
    mem_raddr = scan_base + ADDR_W'(iss_r);
    if (state_r == S_RD_E) begin
      mem_raddr = cur_base_r + ADDR_W'(act_r);
    end
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == S_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = cur_base_r + ADDR_W'(act_r);
      mem_wdata = {1'b1, q_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  // sequencer
  always_comb begin
    logic            any_v;
    logic signed [31:0] best_v;
    logic [7:0]      set_v;
    logic [3:0]      n_v;
    logic [3:0]      t_v;
    logic [2:0]      k_v;
    logic            found_v;

    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    op_nxt       = op_r;
    row_raw_nxt  = row_raw_r;
    nrow_raw_nxt = nrow_raw_r;
    act_raw_nxt  = act_raw_r;
    reward_nxt   = reward_r;
    avail_nxt    = avail_r;
    tie_nxt      = tie_r;
    expl_nxt     = expl_r;
    cur_base_nxt = cur_base_r;
    nxt_base_nxt = nxt_base_r;
    act_nxt      = act_r;
    q_nxt        = q_r;
    sat_nxt      = sat_r;
    m_nxt        = m_r;
    any_nxt      = any_r;
    best_nxt     = best_r;
    best_set_nxt = best_set_r;
    cand_nxt     = cand_r;
    explored_nxt = explored_r;
    iss_nxt      = iss_r;
    rd_pend_nxt  = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    diff_nxt     = diff_r;
    rem_nxt      = rem_r;
    div_cnt_nxt  = div_cnt_r;
    cnt_n_nxt    = cnt_n_r;
    chosen_nxt   = chosen_r;

    out_valid_nxt    = out_valid_r && out_stall;
    out_chosen_nxt   = out_chosen_r;
    out_q_nxt        = out_q_r;
    out_explored_nxt = out_explored_r;
    out_sat_nxt      = out_sat_r;

    any_v   = any_r;
    best_v  = best_r;
    set_v   = best_set_r;
    n_v     = '0;
    t_v     = '0;
    k_v     = rem_r;
    found_v = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_opcode;
          row_raw_nxt  = in_state_index;
          nrow_raw_nxt = in_next_state_index;
          act_raw_nxt  = in_action_index;
          reward_nxt   = in_reward;
          avail_nxt    = in_available_mask & AVAIL_MASK;
          tie_nxt      = in_tie_random;
          expl_nxt     = in_explore_random;
          state_nxt    = S_PREP;
        end
      end

      S_PREP: begin
        cur_base_nxt = ADDR_W'(row_mod(row_raw_r)) * ADDR_W'(NUM_ACTIONS);
        nxt_base_nxt = ADDR_W'(row_mod(nrow_raw_r)) * ADDR_W'(NUM_ACTIONS);
        act_nxt      = act_mod(act_raw_r);
        q_nxt        = '0;
        sat_nxt      = 1'b0;
        m_nxt        = '0;
        any_nxt      = 1'b0;
        best_nxt     = '0;
        best_set_nxt = '0;
        explored_nxt = 1'b0;
        chosen_nxt   = '0;
        iss_nxt      = '0;
        case (op_r)
          OP_UPDATE: state_nxt = S_RD_E;
          OP_GREEDY: state_nxt = S_SCAN;
          OP_EPS_GREEDY: begin
            if ({1'b0, expl_r} < thr_r) begin
              cand_nxt     = avail_r;
              explored_nxt = 1'b1;
              state_nxt    = S_PICK;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_RD_E: state_nxt = S_GET_E;

      S_GET_E: begin
        q_nxt     = wvalid ? wq : 32'sd0;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        // issue one read a cycle, fold in the word read the cycle before
        if (iss_r < scan_len) begin
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = iss_r[IDX_W-1:0];
          iss_nxt     = iss_r + 1'b1;
        end
        if (rd_pend_r) begin
          if (op_r == OP_UPDATE) begin
            if (wvalid && wq > m_r) begin
              m_nxt = wq;
            end
          end else if (((avail_r >> rd_idx_r) & 8'd1) != 8'd0 && wvalid) begin
            if (!any_r || wq > best_r) begin
              best_v = wq;
              set_v  = 8'd1 << rd_idx_r;
              any_v  = 1'b1;
            end else if (wq == best_r) begin
              set_v = best_set_r | (8'd1 << rd_idx_r);
            end
          end
          any_nxt      = any_v;
          best_nxt     = best_v;
          best_set_nxt = set_v;
          if (rd_idx_r == scan_last_idx) begin
            if (op_r == OP_UPDATE) begin
              state_nxt = S_MUL_R;
            end else begin
              cand_nxt  = any_v ? set_v : avail_r;
              state_nxt = S_PICK;
            end
          end
        end
      end

      S_MUL_R: state_nxt = S_ADD_R;

      S_ADD_R: begin
        q_nxt   = $signed(sum_sat[31:0]);
        sat_nxt = sat_r | sum_sat[32];
        state_nxt = (m_r != 32'sd0) ? S_MUL_D : S_WRITE;
      end

      S_MUL_D: state_nxt = S_DIFF;

      S_DIFF: begin
        diff_nxt  = 35'(scaled) - 35'(q_r);
        state_nxt = S_MUL_L;
      end

      S_MUL_L: state_nxt = S_ADD_L;

      S_ADD_L: begin
        q_nxt     = $signed(sum_sat[31:0]);
        sat_nxt   = sat_r | sum_sat[32];
        state_nxt = S_WRITE;
      end

      S_WRITE: state_nxt = S_DONE;

      S_PICK: begin
        for (int j = 0; j < 8; j++) begin
          n_v = n_v + 4'(cand_r[j]);
        end
        if (n_v == 4'd0) begin
          chosen_nxt = '0;
          state_nxt  = S_DONE;
        end else begin
          cnt_n_nxt   = n_v;
          rem_nxt     = '0;
          div_cnt_nxt = 4'd15;
          state_nxt   = S_DIV;
        end
      end

      S_DIV: begin
        // tie_random mod count, one bit a cycle, MSB first
        t_v = {rem_r, tie_r[15]};
        if (t_v >= cnt_n_r) begin
          t_v = t_v - cnt_n_r;
        end
        rem_nxt = t_v[2:0];
        tie_nxt = tie_r << 1;
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == 4'd0) begin
          state_nxt = S_SEL;
        end
      end

      S_SEL: begin
        for (int j = 0; j < 8; j++) begin
          if (cand_r[j] && !found_v) begin
            if (k_v == 3'd0) begin
              chosen_nxt = 3'(j);
              found_v    = 1'b1;
            end else begin
              k_v = k_v - 1'b1;
            end
          end
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_chosen_nxt   = chosen_r;
          out_q_nxt        = q_r;
          out_explored_nxt = explored_r;
          out_sat_nxt      = sat_r;
          state_nxt        = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      lr_r        <= LR_RESET;
      disc_r      <= DISCOUNT_RESET;
      thr_r       <= EXPLORE_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LEARNING_RATE:     lr_r   <= cfg_data;
          REG_DISCOUNT_FACTOR:   disc_r <= cfg_data;
          REG_EXPLORE_THRESHOLD: thr_r  <= cfg_data;
          default: ;
        endcase
      end
    end
    op_r           <= op_nxt;
    row_raw_r      <= row_raw_nxt;
    nrow_raw_r     <= nrow_raw_nxt;
    act_raw_r      <= act_raw_nxt;
    reward_r       <= reward_nxt;
    avail_r        <= avail_nxt;
    tie_r          <= tie_nxt;
    expl_r         <= expl_nxt;
    cur_base_r     <= cur_base_nxt;
    nxt_base_r     <= nxt_base_nxt;
    act_r          <= act_nxt;
    q_r            <= q_nxt;
    sat_r          <= sat_nxt;
    m_r            <= m_nxt;
    any_r          <= any_nxt;
    best_r         <= best_nxt;
    best_set_r     <= best_set_nxt;
    cand_r         <= cand_nxt;
    explored_r     <= explored_nxt;
    iss_r          <= iss_nxt;
    rd_idx_r       <= rd_idx_nxt;
    diff_r         <= diff_nxt;
    rem_r          <= rem_nxt;
    div_cnt_r      <= div_cnt_nxt;
    cnt_n_r        <= cnt_n_nxt;
    chosen_r       <= chosen_nxt;
    out_chosen_r   <= out_chosen_nxt;
    out_q_r        <= out_q_nxt;
    out_explored_r <= out_explored_nxt;
    out_sat_r      <= out_sat_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/qtus_checker.sv
// ---------------------------------------------------------------------------
// qtus_checker
// Port-level checks on the Q-table engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module qtus_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [2:0]         out_chosen_action,
  input wire logic signed [31:0] out_new_q_value,
  input wire logic               out_explored,
  input wire logic               out_saturated
);

  // one request at a time: busy straight after taking a word
  `QTUS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  `QTUS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_new_q_value) && $stable(out_chosen_action))

  // only updates clamp, and updates choose nothing
  `QTUS_ASSERT_IMP(a_sat_is_update, clk, rst_n, out_valid && out_saturated, out_chosen_action == 3'd0 && !out_explored)

  // exploration is a choice: no Q value, no clamp
  `QTUS_ASSERT_IMP(a_explore_is_choice, clk, rst_n, out_valid && out_explored, out_new_q_value == 32'sd0 && !out_saturated)

endmodule

bind q_table_update_and_select qtus_checker u_qtus_checker (.*);

`default_nettype wire
